// ----- rtl/core/lbbf_pkg.sv -----
// ----------------------------------------------------------------------------
// lbbf_pkg
// shared types, constants and register codes of the labelled-region
// bounding box finder
// ----------------------------------------------------------------------------
`default_nettype none

package lbbf_pkg;

  // volume limits and label register count
  localparam int MAX_LABELS = 4;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_DEPTH  = 1024;
  localparam int LABEL_REGS = 4;

  // field widths
  localparam int XY_W    = 12;
  localparam int SLICE_W = 10;
  localparam int LABEL_W = 16;
  localparam int COUNT_W = 3;
  localparam int PXY_W   = 13;
  localparam int PSL_W   = 11;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LABEL_A     = 3'd0;
  localparam logic [2:0] REG_LABEL_B     = 3'd1;
  localparam logic [2:0] REG_LABEL_C     = 3'd2;
  localparam logic [2:0] REG_LABEL_D     = 3'd3;
  localparam logic [2:0] REG_LABEL_COUNT = 3'd4;

  // padding added to an extent
  localparam int PAD_BASE = 4;

  // reset values of the running bounds
  localparam logic [XY_W-1:0]    XY_LOW_INIT    = '1;
  localparam logic [SLICE_W-1:0] SLICE_LOW_INIT = '1;

  // label configuration seen by the matcher
  typedef struct packed {
    logic [LABEL_REGS-1:0][LABEL_W-1:0] labels;
    logic [COUNT_W-1:0]                 count;
  } lbbf_cfg_t;

  // one registered voxel
  typedef struct packed {
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    y;
    logic [SLICE_W-1:0] slice;
    logic               hit;
    logic               last;
  } lbbf_vox_t;

  // final bounds of one volume
  typedef struct packed {
    logic               found;
    logic [XY_W-1:0]    lo_x;
    logic [XY_W-1:0]    hi_x;
    logic [XY_W-1:0]    lo_y;
    logic [XY_W-1:0]    hi_y;
    logic [SLICE_W-1:0] lo_s;
    logic [SLICE_W-1:0] hi_s;
  } lbbf_bounds_t;

endpackage

`default_nettype wire

// ----- rtl/core/lbbf_regs.sv -----
// ----------------------------------------------------------------------------
// lbbf_regs
// apb-style register file holding the four labels and the label count
// ----------------------------------------------------------------------------
`default_nettype none

module lbbf_regs
  import lbbf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output lbbf_cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LABEL_A:     cfg.labels[0] <= pwdata[LABEL_W-1:0];
        REG_LABEL_B:     cfg.labels[1] <= pwdata[LABEL_W-1:0];
        REG_LABEL_C:     cfg.labels[2] <= pwdata[LABEL_W-1:0];
        REG_LABEL_D:     cfg.labels[3] <= pwdata[LABEL_W-1:0];
        REG_LABEL_COUNT: cfg.count     <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_LABEL_A:     prdata = {(PDATA_W-LABEL_W)'(0), cfg.labels[0]};
      REG_LABEL_B:     prdata = {(PDATA_W-LABEL_W)'(0), cfg.labels[1]};
      REG_LABEL_C:     prdata = {(PDATA_W-LABEL_W)'(0), cfg.labels[2]};
      REG_LABEL_D:     prdata = {(PDATA_W-LABEL_W)'(0), cfg.labels[3]};
      REG_LABEL_COUNT: prdata = {(PDATA_W-COUNT_W)'(0), cfg.count};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/lbbf_match.sv -----
// ----------------------------------------------------------------------------
// lbbf_match
// label compare and volume range check, then the voxel input register
// ----------------------------------------------------------------------------
`default_nettype none

module lbbf_match
  import lbbf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lbbf_cfg_t          cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [XY_W-1:0]    x_pos,
  input  wire logic [XY_W-1:0]    y_pos,
  input  wire logic [SLICE_W-1:0] slice_index,
  input  wire logic [LABEL_W-1:0] label_value,
  input  wire logic               last_voxel,
  output logic                    vox_valid,
  output lbbf_vox_t               vox,
  input  wire logic               vox_ready
);

  logic label_hit;
  logic in_volume;

  // compare against every enabled label register
  always_comb begin
    label_hit = 1'b0;
    for (int i = 0; i < LABEL_REGS; i++) begin
      if (i < MAX_LABELS && COUNT_W'(i) < cfg.count && cfg.labels[i] == label_value) begin
        label_hit = 1'b1;
      end
    end
  end

  // coordinates outside the volume never match
  assign in_volume = ({5'b0, x_pos} < 17'(MAX_WIDTH)) &&
                     ({5'b0, y_pos} < 17'(MAX_HEIGHT)) &&
                     ({7'b0, slice_index} < 17'(MAX_DEPTH));

  assign in_ready = !vox_valid || vox_ready;

  // voxel register
  always_ff @(posedge clk) begin
    if (rst) begin
      vox_valid <= 1'b0;
    end else if (in_ready) begin
      vox_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      vox.x     <= x_pos;
      vox.y     <= y_pos;
      vox.slice <= slice_index;
      vox.hit   <= label_hit && in_volume;
      vox.last  <= last_voxel;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lbbf_accum.sv -----
// ----------------------------------------------------------------------------
// lbbf_accum
// running minimum and maximum of the matching voxels, with a snapshot
// register that takes the final bounds on the last voxel
// ----------------------------------------------------------------------------
`default_nettype none

module lbbf_accum
  import lbbf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   vox_valid,
  input  wire lbbf_vox_t vox,
  output logic        vox_ready,
  output logic        snap_valid,
  output lbbf_bounds_t snap,
  input  wire logic   snap_ready
);

  lbbf_bounds_t bounds;
  lbbf_bounds_t bounds_next;
  logic         take;
  logic         snap_free;

  assign snap_free = !snap_valid || snap_ready;
  assign vox_ready = !vox.last || snap_free;
  assign take      = vox_valid && vox_ready;

  // bounds including the current voxel
  always_comb begin
    bounds_next = bounds;
    if (vox.hit) begin
      bounds_next.found = 1'b1;
      if (vox.x < bounds.lo_x)     bounds_next.lo_x = vox.x;
      if (vox.x > bounds.hi_x)     bounds_next.hi_x = vox.x;
      if (vox.y < bounds.lo_y)     bounds_next.lo_y = vox.y;
      if (vox.y > bounds.hi_y)     bounds_next.hi_y = vox.y;
      if (vox.slice < bounds.lo_s) bounds_next.lo_s = vox.slice;
      if (vox.slice > bounds.hi_s) bounds_next.hi_s = vox.slice;
    end
  end

  // running bounds, cleared after each volume
  always_ff @(posedge clk) begin
    if (rst || (take && vox.last)) begin
      bounds.found <= 1'b0;
      bounds.lo_x  <= XY_LOW_INIT;
      bounds.hi_x  <= '0;
      bounds.lo_y  <= XY_LOW_INIT;
      bounds.hi_y  <= '0;
      bounds.lo_s  <= SLICE_LOW_INIT;
      bounds.hi_s  <= '0;
    end else if (take) begin
      bounds <= bounds_next;
    end
  end

  // snapshot of the finished volume
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take && vox.last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (take && vox.last) begin
      snap <= bounds_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lbbf_pad.sv -----
// ----------------------------------------------------------------------------
// lbbf_pad
// padded sizes from the final bounds, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module lbbf_pad
  import lbbf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          snap_valid,
  input  wire lbbf_bounds_t  snap,
  output logic               snap_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               found,
  output logic [XY_W-1:0]    min_x,
  output logic [XY_W-1:0]    max_x,
  output logic [XY_W-1:0]    min_y,
  output logic [XY_W-1:0]    max_y,
  output logic [SLICE_W-1:0] min_slice,
  output logic [SLICE_W-1:0] max_slice,
  output logic [PXY_W-1:0]   padded_width,
  output logic [PXY_W-1:0]   padded_height,
  output logic [PSL_W-1:0]   padded_depth
);

  logic [PXY_W-1:0] ext_w;
  logic [PXY_W-1:0] ext_h;
  logic [PSL_W-1:0] ext_d;
  logic [PXY_W-1:0] pad_w;
  logic [PXY_W-1:0] pad_h;
  logic [PSL_W-1:0] pad_d;

  // extent plus four, plus one more when odd
  always_comb begin
    ext_w = {1'b0, snap.hi_x} - {1'b0, snap.lo_x} + PXY_W'(1);
    ext_h = {1'b0, snap.hi_y} - {1'b0, snap.lo_y} + PXY_W'(1);
    ext_d = {1'b0, snap.hi_s} - {1'b0, snap.lo_s} + PSL_W'(1);
    pad_w = ext_w + PXY_W'(PAD_BASE) + {{(PXY_W-1){1'b0}}, ext_w[0]};
    pad_h = ext_h + PXY_W'(PAD_BASE) + {{(PXY_W-1){1'b0}}, ext_h[0]};
    pad_d = ext_d + PSL_W'(PAD_BASE) + {{(PSL_W-1){1'b0}}, ext_d[0]};
  end

  assign snap_ready = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
    if (snap_valid && snap_ready) begin
      found         <= snap.found;
      min_x         <= snap.lo_x;
      max_x         <= snap.hi_x;
      min_y         <= snap.lo_y;
      max_y         <= snap.hi_y;
      min_slice     <= snap.lo_s;
      max_slice     <= snap.hi_s;
      padded_width  <= snap.found ? pad_w : '0;
      padded_height <= snap.found ? pad_h : '0;
      padded_depth  <= snap.found ? pad_d : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/label_bounding_box_finder.sv -----
// ----------------------------------------------------------------------------
// label_bounding_box_finder
// bounding box of the voxels carrying any of up to four labels, one result
// per volume with the six bounds and the padded sizes
// ----------------------------------------------------------------------------
//   channel   direction  handshake               request
//   voxel     in         in_valid / in_ready     x, y, slice, label, last flag
//   result    out        out_valid / out_ready   found, bounds, padded sizes
//   config    in         psel/penable/pready     label_a..d, label_count
//
// one voxel is taken every cycle while in_ready is high; a result is offered
// once the last voxel of a volume has passed the input register, the bounds
// snapshot and the result register. reset clears the bounds and the labels. when
// the result is stalled the pipeline keeps taking voxels until a third
// finished volume waits for the snapshot stage, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module label_bounding_box_finder
  import lbbf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [XY_W-1:0]    x_pos,
  input  wire logic [XY_W-1:0]    y_pos,
  input  wire logic [SLICE_W-1:0] slice_index,
  input  wire logic [LABEL_W-1:0] label_value,
  input  wire logic               last_voxel,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic      [XY_W-1:0]    min_x,
  output logic      [XY_W-1:0]    max_x,
  output logic      [XY_W-1:0]    min_y,
  output logic      [XY_W-1:0]    max_y,
  output logic      [SLICE_W-1:0] min_slice,
  output logic      [SLICE_W-1:0] max_slice,
  output logic      [PXY_W-1:0]   padded_width,
  output logic      [PXY_W-1:0]   padded_height,
  output logic      [PSL_W-1:0]   padded_depth
);

  lbbf_cfg_t    cfg;
  lbbf_vox_t    vox;
  logic         vox_valid;
  logic         vox_ready;
  lbbf_bounds_t snap;
  logic         snap_valid;
  logic         snap_ready;

  // configuration registers
  lbbf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // label match and input register
  lbbf_match u_match (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .slice_index (slice_index),
    .label_value (label_value),
    .last_voxel  (last_voxel),
    .vox_valid   (vox_valid),
    .vox         (vox),
    .vox_ready   (vox_ready)
  );

  // running bounds
  lbbf_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .vox_valid  (vox_valid),
    .vox        (vox),
    .vox_ready  (vox_ready),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  // padded sizes and result register
  lbbf_pad u_pad (
    .clk           (clk),
    .rst           (rst),
    .snap_valid    (snap_valid),
    .snap          (snap),
    .snap_ready    (snap_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .min_x         (min_x),
    .max_x         (max_x),
    .min_y         (min_y),
    .max_y         (max_y),
    .min_slice     (min_slice),
    .max_slice     (max_slice),
    .padded_width  (padded_width),
    .padded_height (padded_height),
    .padded_depth  (padded_depth)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lbbf_checker.sv -----
// ----------------------------------------------------------------------------
// lbbf_props
// port-level checks on the result channel of the bounding box finder
// ----------------------------------------------------------------------------
`default_nettype none

module lbbf_props
  import lbbf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               found,
  input wire logic [XY_W-1:0]    min_x,
  input wire logic [XY_W-1:0]    max_x,
  input wire logic [XY_W-1:0]    min_y,
  input wire logic [XY_W-1:0]    max_y,
  input wire logic [SLICE_W-1:0] min_slice,
  input wire logic [SLICE_W-1:0] max_slice,
  input wire logic [PXY_W-1:0]   padded_width,
  input wire logic [PXY_W-1:0]   padded_height,
  input wire logic [PSL_W-1:0]   padded_depth
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its bounds
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(min_x) && $stable(max_x) &&
      $stable(min_y) && $stable(max_y) && $stable(min_slice) && $stable(max_slice))
    else $error("result changed while stalled");

  // a found box is ordered and its padded sizes are even
  a_found_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> min_x <= max_x && min_y <= max_y && min_slice <= max_slice &&
      !padded_width[0] && !padded_height[0] && !padded_depth[0])
    else $error("inconsistent bounding box");

  // an empty volume reports cleared bounds and no size
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> min_x == XY_LOW_INIT && max_x == '0 &&
      min_y == XY_LOW_INIT && max_y == '0 && min_slice == SLICE_LOW_INIT &&
      max_slice == '0 && padded_width == '0 && padded_height == '0 && padded_depth == '0)
    else $error("empty volume with non-reset bounds");

endmodule

bind label_bounding_box_finder lbbf_props u_lbbf_props (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .found         (found),
  .min_x         (min_x),
  .max_x         (max_x),
  .min_y         (min_y),
  .max_y         (max_y),
  .min_slice     (min_slice),
  .max_slice     (max_slice),
  .padded_width  (padded_width),
  .padded_height (padded_height),
  .padded_depth  (padded_depth)
);

`default_nettype wire

// ----- tb/sv/lbbf_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbbf_checker
// watches the configuration port and both request channels of the bounding
// box finder, keeps its own running bounds per volume and compares every
// result request field by field with the oldest predicted box
// ----------------------------------------------------------------------------

module lbbf_checker
  import lbbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [XY_W-1:0]    x_pos,
  input  logic [XY_W-1:0]    y_pos,
  input  logic [SLICE_W-1:0] slice_index,
  input  logic [LABEL_W-1:0] label_value,
  input  logic               last_voxel,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               found,
  input  logic [XY_W-1:0]    min_x,
  input  logic [XY_W-1:0]    max_x,
  input  logic [XY_W-1:0]    min_y,
  input  logic [XY_W-1:0]    max_y,
  input  logic [SLICE_W-1:0] min_slice,
  input  logic [SLICE_W-1:0] max_slice,
  input  logic [PXY_W-1:0]   padded_width,
  input  logic [PXY_W-1:0]   padded_height,
  input  logic [PSL_W-1:0]   padded_depth,
  output int                 errors,
  output int                 boxes_due,
  output int                 voxels_taken,
  output int                 boxes_checked,
  output int                 boxes_found
);

  // one predicted result: bounds plus padded sizes
  typedef struct packed {
    lbbf_bounds_t       bounds;
    logic [PXY_W-1:0]   pad_w;
    logic [PXY_W-1:0]   pad_h;
    logic [PSL_W-1:0]   pad_d;
  } box_t;

  lbbf_cfg_t          label_cfg;
  lbbf_bounds_t       run_bounds;
  box_t               boxes_owed[$];
  box_t               next_box;
  box_t               want;
  logic [2:0]         reg_idx;
  logic [PDATA_W-1:0] reg_val;
  logic               reg_known;
  int                 err_n = 0;
  int                 vox_n = 0;
  int                 chk_n = 0;
  int                 hit_n = 0;

  // bounds of a volume before any voxel has matched
  function automatic lbbf_bounds_t empty_bounds();
    lbbf_bounds_t b;
    b.found = 1'b0;
    b.lo_x  = XY_LOW_INIT;
    b.hi_x  = '0;
    b.lo_y  = XY_LOW_INIT;
    b.hi_y  = '0;
    b.lo_s  = SLICE_LOW_INIT;
    b.hi_s  = '0;
    return b;
  endfunction

  // a label matches when it equals one of the enabled label registers
  function automatic logic label_enabled(lbbf_cfg_t c, logic [LABEL_W-1:0] lab);
    int   n;
    logic hit;
    n = (int'(c.count) > MAX_LABELS) ? MAX_LABELS : int'(c.count);
    if (n > LABEL_REGS) n = LABEL_REGS;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (c.labels[i] == lab) hit = 1'b1;
    end
    return hit;
  endfunction

  // extent rounded up to even, plus the fixed margin
  function automatic int padded_extent(int lo, int hi);
    int ext;
    ext = hi - lo + 1;
    return (ext % 2 == 0) ? ext + PAD_BASE : ext + PAD_BASE + 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    err_n++;
    $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, exp_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      label_cfg  = '0;
      run_bounds = empty_bounds();
      boxes_owed.delete();
    end else begin
      reg_idx = paddr[PADDR_W-1:2];

      // register writes, out-of-range indexes are dropped
      if (psel && penable && pready && pwrite) begin
        case (reg_idx)
          REG_LABEL_A, REG_LABEL_B, REG_LABEL_C, REG_LABEL_D: begin
            label_cfg.labels[reg_idx[1:0]] = pwdata[LABEL_W-1:0];
          end
          REG_LABEL_COUNT: begin
            label_cfg.count = pwdata[COUNT_W-1:0];
          end
          default: ;
        endcase
      end

      // register read-back
      if (psel && penable && pready && !pwrite) begin
        reg_known = 1'b1;
        reg_val   = '0;
        case (reg_idx)
          REG_LABEL_A, REG_LABEL_B, REG_LABEL_C, REG_LABEL_D: begin
            reg_val[LABEL_W-1:0] = label_cfg.labels[reg_idx[1:0]];
          end
          REG_LABEL_COUNT: begin
            reg_val[COUNT_W-1:0] = label_cfg.count;
          end
          default: begin
            reg_known = 1'b0;
          end
        endcase
        if (reg_known && prdata !== reg_val) report_mismatch("prdata", prdata, reg_val);
      end

      // voxel request: widen the running box, close it on the last voxel
      if (in_valid && in_ready) begin
        vox_n++;
        if (int'(x_pos) < MAX_WIDTH && int'(y_pos) < MAX_HEIGHT &&
            int'(slice_index) < MAX_DEPTH && label_enabled(label_cfg, label_value)) begin
          if (x_pos < run_bounds.lo_x) run_bounds.lo_x = x_pos;
          if (x_pos > run_bounds.hi_x) run_bounds.hi_x = x_pos;
          if (y_pos < run_bounds.lo_y) run_bounds.lo_y = y_pos;
          if (y_pos > run_bounds.hi_y) run_bounds.hi_y = y_pos;
          if (slice_index < run_bounds.lo_s) run_bounds.lo_s = slice_index;
          if (slice_index > run_bounds.hi_s) run_bounds.hi_s = slice_index;
          run_bounds.found = 1'b1;
        end
        if (last_voxel) begin
          next_box.bounds = run_bounds;
          if (run_bounds.found) begin
            next_box.pad_w = PXY_W'(padded_extent(int'(run_bounds.lo_x),
                                                  int'(run_bounds.hi_x)));
            next_box.pad_h = PXY_W'(padded_extent(int'(run_bounds.lo_y),
                                                  int'(run_bounds.hi_y)));
            next_box.pad_d = PSL_W'(padded_extent(int'(run_bounds.lo_s),
                                                  int'(run_bounds.hi_s)));
          end else begin
            next_box.pad_w = '0;
            next_box.pad_h = '0;
            next_box.pad_d = '0;
          end
          boxes_owed.push_back(next_box);
          run_bounds = empty_bounds();
        end
      end

      // result request against the oldest predicted box
      if (out_valid && out_ready) begin
        if (boxes_owed.size() == 0) begin
          report_mismatch("result with no volume outstanding", 1, 0);
        end else begin
          want = boxes_owed.pop_front();
          chk_n++;
          if (want.bounds.found) hit_n++;
          if (found !== want.bounds.found) report_mismatch("found", found, want.bounds.found);
          if (min_x !== want.bounds.lo_x) report_mismatch("min_x", min_x, want.bounds.lo_x);
          if (max_x !== want.bounds.hi_x) report_mismatch("max_x", max_x, want.bounds.hi_x);
          if (min_y !== want.bounds.lo_y) report_mismatch("min_y", min_y, want.bounds.lo_y);
          if (max_y !== want.bounds.hi_y) report_mismatch("max_y", max_y, want.bounds.hi_y);
          if (min_slice !== want.bounds.lo_s)
            report_mismatch("min_slice", min_slice, want.bounds.lo_s);
          if (max_slice !== want.bounds.hi_s)
            report_mismatch("max_slice", max_slice, want.bounds.hi_s);
          if (padded_width !== want.pad_w)
            report_mismatch("padded_width", padded_width, want.pad_w);
          if (padded_height !== want.pad_h)
            report_mismatch("padded_height", padded_height, want.pad_h);
          if (padded_depth !== want.pad_d)
            report_mismatch("padded_depth", padded_depth, want.pad_d);
        end
      end
    end

    errors        <= err_n;
    boxes_due     <= boxes_owed.size();
    voxels_taken  <= vox_n;
    boxes_checked <= chk_n;
    boxes_found   <= hit_n;
  end

endmodule

// ----- tb/sv/tb_label_bounding_box_finder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_label_bounding_box_finder
// drives voxel volumes and label settings into the bounding box finder, with
// random gaps on the voxel side and random stalls on the result side; the
// checker beside the block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------

module tb_label_bounding_box_finder;
  import lbbf_pkg::*;

  localparam int         VOXEL_TARGET  = 1950;
  localparam int         MAX_PAUSE     = 17;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         XY_TOP        = MAX_WIDTH - 1;
  localparam int         SLICE_TOP     = MAX_DEPTH - 1;
  localparam int         SPREAD        = 15;
  localparam logic [2:0] REG_SPARE_LO  = REG_LABEL_COUNT + 3'd1;
  localparam logic [2:0] REG_SPARE_HI  = '1;

  // how often either side pauses
  typedef enum logic [1:0] {PACE_STEADY, PACE_BURSTY, PACE_SPARSE} pace_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [XY_W-1:0]    x_pos       = '0;
  logic [XY_W-1:0]    y_pos       = '0;
  logic [SLICE_W-1:0] slice_index = '0;
  logic [LABEL_W-1:0] label_value = '0;
  logic               last_voxel  = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               found;
  logic [XY_W-1:0]    min_x, max_x, min_y, max_y;
  logic [SLICE_W-1:0] min_slice, max_slice;
  logic [PXY_W-1:0]   padded_width, padded_height;
  logic [PSL_W-1:0]   padded_depth;

  int                 errors, boxes_due, voxels_taken, boxes_checked, boxes_found;
  pace_t              pace = PACE_STEADY;
  logic [LABEL_W-1:0] lab_set [LABEL_REGS];
  int                 voxels_sent   = 0;
  int                 settings_used = 0;

  always #5 clk = ~clk;

  label_bounding_box_finder u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .slice_index   (slice_index),
    .label_value   (label_value),
    .last_voxel    (last_voxel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .min_x         (min_x),
    .max_x         (max_x),
    .min_y         (min_y),
    .max_y         (max_y),
    .min_slice     (min_slice),
    .max_slice     (max_slice),
    .padded_width  (padded_width),
    .padded_height (padded_height),
    .padded_depth  (padded_depth)
  );

  lbbf_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .slice_index   (slice_index),
    .label_value   (label_value),
    .last_voxel    (last_voxel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .min_x         (min_x),
    .max_x         (max_x),
    .min_y         (min_y),
    .max_y         (max_y),
    .min_slice     (min_slice),
    .max_slice     (max_slice),
    .padded_width  (padded_width),
    .padded_height (padded_height),
    .padded_depth  (padded_depth),
    .errors        (errors),
    .boxes_due     (boxes_due),
    .voxels_taken  (voxels_taken),
    .boxes_checked (boxes_checked),
    .boxes_found   (boxes_found)
  );

  // pause before the next request, shaped by the current pace
  function automatic int pause_len();
    case (pace)
      PACE_STEADY: return 0;
      PACE_BURSTY: return $urandom_range(0, MAX_PAUSE);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_PAUSE) : 0;
    endcase
  endfunction

  // label value weighted towards the extremes
  function automatic logic [LABEL_W-1:0] pick_label();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LABEL_W'($urandom);
    endcase
  endfunction

  // one register access, setup then access phase; psel stays high afterwards
  task automatic cfg_access(input logic [2:0] idx, input logic wr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // write all label registers, maybe poke an unused index, then read back
  task automatic load_labels(input logic [LABEL_W-1:0] la, lb, lc, ld,
                             input logic [COUNT_W-1:0] n, input logic poke_spare);
    logic [2:0]         idx [5];
    logic [PDATA_W-1:0] val [5];
    logic [PDATA_W-1:0] junk;
    junk = $urandom;
    idx  = '{REG_LABEL_A, REG_LABEL_B, REG_LABEL_C, REG_LABEL_D, REG_LABEL_COUNT};
    val  = '{{junk[31:16], la}, {junk[15:0], lb}, {junk[31:16], lc},
             {junk[15:0], ld}, {junk[31:3], n}};
    lab_set[0] = la;
    lab_set[1] = lb;
    lab_set[2] = lc;
    lab_set[3] = ld;
    for (int i = 0; i < 5; i++) cfg_access(idx[i], 1'b1, val[i]);
    if (poke_spare) cfg_access(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 1'b1, $urandom);
    for (int i = 0; i < 5; i++) cfg_access(idx[i], 1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // one voxel request, after a random pause
  task automatic send_voxel(input logic [XY_W-1:0] x, y, input logic [SLICE_W-1:0] s,
                            input logic [LABEL_W-1:0] lab, input logic last);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    x_pos       <= x;
    y_pos       <= y;
    slice_index <= s;
    label_value <= lab;
    last_voxel  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    voxels_sent++;
  endtask

  // drain every owed box, then let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (boxes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: stall results for random pauses shaped by the current pace
  initial begin : drain
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = pause_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (gap - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [LABEL_W-1:0] pick [LABEL_REGS];
    logic [COUNT_W-1:0] n;
    logic [XY_W-1:0]    x, y, base_x, base_y;
    logic [SLICE_W-1:0] s, base_s;
    logic [LABEL_W-1:0] lab;
    logic               local_box;
    int                 n_vol, len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // labels still at reset with count zero: nothing may match, not even label 0
    send_voxel('0, '0, '0, '0, 1'b0);
    send_voxel('1, '1, '1, '0, 1'b1);
    wait_idle();

    // four labels with extreme values, an unused register index poked too
    load_labels(16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 3'd4, 1'b1);
    // full extents in every axis, one voxel with an unknown label
    send_voxel('0, '1, '0, 16'h8001, 1'b0);
    send_voxel('1, '0, '1, 16'hFFFF, 1'b0);
    send_voxel(12'd17, 12'd33, 10'd5, 16'h5555, 1'b0);
    send_voxel(12'd100, 12'd200, 10'd300, 16'h1234, 1'b1);
    // single voxel, odd extent of one
    send_voxel(12'd7, 12'd9, 10'd11, 16'h0000, 1'b1);
    // even extents in every axis, last voxel does not match
    send_voxel(12'd5, 12'd5, 10'd5, 16'h1234, 1'b0);
    send_voxel(12'd10, 12'd6, 10'd8, 16'h0000, 1'b0);
    send_voxel('1, '1, '1, 16'h7777, 1'b1);
    wait_idle();

    // count above the register count enables all four
    load_labels(16'h0000, 16'hFFFF, 16'h1234, 16'h8001, '1, 1'b0);
    send_voxel(12'd2, 12'd3, 10'd4, 16'h8001, 1'b1);
    wait_idle();

    // count of two masks the third label
    load_labels(16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 3'd2, 1'b0);
    send_voxel(12'd1, 12'd1, 10'd1, 16'h1234, 1'b0);
    send_voxel(12'd9, 12'd9, 10'd9, 16'hFFFF, 1'b1);

    // random settings, each followed by a handful of volumes
    while (voxels_sent < VOXEL_TARGET) begin
      wait_idle();
      for (int i = 0; i < LABEL_REGS; i++) pick[i] = pick_label();
      case ($urandom_range(0, 5))
        0:       n = '0;
        1:       n = COUNT_W'(MAX_LABELS);
        2:       n = '1;
        default: n = COUNT_W'($urandom_range(0, 7));
      endcase
      load_labels(pick[0], pick[1], pick[2], pick[3], n, $urandom_range(0, 3) == 0);
      pace  = pace_t'($urandom_range(0, 2));
      n_vol = $urandom_range(2, 8);
      repeat (n_vol) begin
        len       = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
        local_box = ($urandom_range(0, 1) == 1);
        base_x    = XY_W'($urandom_range(0, XY_TOP - SPREAD));
        base_y    = XY_W'($urandom_range(0, XY_TOP - SPREAD));
        base_s    = SLICE_W'($urandom_range(0, SLICE_TOP - SPREAD));
        for (int v = 0; v < len; v++) begin
          if (local_box) begin
            x = base_x + XY_W'($urandom_range(0, SPREAD));
            y = base_y + XY_W'($urandom_range(0, SPREAD));
            s = base_s + SLICE_W'($urandom_range(0, SPREAD));
          end else begin
            x = XY_W'($urandom_range(0, XY_TOP));
            y = XY_W'($urandom_range(0, XY_TOP));
            s = SLICE_W'($urandom_range(0, SLICE_TOP));
          end
          // occasional corner of the volume
          if ($urandom_range(0, 11) == 0) begin
            x = $urandom_range(0, 1) ? '1 : '0;
            y = $urandom_range(0, 1) ? '1 : '0;
            s = $urandom_range(0, 1) ? '1 : '0;
          end
          lab = ($urandom_range(0, 9) < 6) ? lab_set[$urandom_range(0, LABEL_REGS - 1)]
                                           : LABEL_W'($urandom);
          send_voxel(x, y, s, lab, v == len - 1);
        end
      end
    end

    wait_idle();
    $display("%0d voxels in %0d label settings, %0d boxes checked, %0d of them non-empty",
             voxels_taken, settings_used, boxes_checked, boxes_found);
    $display("%0d mismatches reported", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5000000;
    $display("run did not finish in time");
    $display("FAILURE");
    $finish;
  end

endmodule
